@@ rtl/bce_pkg.sv @@
// shared types and constants of the color expansion blit
`default_nettype none

package bce_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_FORE_COLOR    = 3'd2,
        CFG_BACK_COLOR    = 3'd3,
        CFG_PLACE_X       = 3'd4,
        CFG_PLACE_Y       = 3'd5,
        CFG_CHANNEL_COUNT = 3'd6,
        CFG_CENTER_MODE   = 3'd7
    } t_cfg_idx;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned DIM_W      = 9;
    localparam int unsigned COORD_W    = 16;
    localparam int unsigned COLOR_W    = 16;

    // channel count codes
    localparam logic [7:0] CH_GREY = 8'd1;
    localparam logic [7:0] CH_RGB  = 8'd3;

    // color for unsupported channel counts
    localparam logic [COLOR_W-1:0] COLOR_RED = 16'hF800;

    // destination position of one pixel
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } t_pos;

endpackage

`default_nettype wire

@@ rtl/bce_pos.sv @@
// raster position counters and destination coordinate generation
`default_nettype none

module bce_pos
    import bce_pkg::*;
#(
    parameter int unsigned MAX_DIM = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_adv,
    input  wire logic [DIM_W-1:0]   i_width,
    input  wire logic [DIM_W-1:0]   i_height,
    input  wire logic [COORD_W-1:0] i_place_x,
    input  wire logic [COORD_W-1:0] i_place_y,
    input  wire logic               i_center,
    output t_pos                    o_pos
);

    localparam int unsigned CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int unsigned EW = $clog2(MAX_DIM + 1);

    logic [CW-1:0]      r_col;
    logic [CW-1:0]      r_row;
    logic [EW-1:0]      w_eff;
    logic [EW-1:0]      h_eff;
    logic [EW:0]        col_inc;
    logic [EW:0]        row_inc;
    logic               row_end;
    logic               frame_end;
    logic [COORD_W-1:0] org_x;
    logic [COORD_W-1:0] org_y;

    // effective image size, zero acts as one, clamp at the maximum
    always_comb begin
        if (i_width == '0) begin
            w_eff = EW'(1);
        end else if (int'(i_width) > MAX_DIM) begin
            w_eff = EW'(MAX_DIM);
        end else begin
            w_eff = EW'(i_width);
        end
        if (i_height == '0) begin
            h_eff = EW'(1);
        end else if (int'(i_height) > MAX_DIM) begin
            h_eff = EW'(MAX_DIM);
        end else begin
            h_eff = EW'(i_height);
        end
    end

    // row and frame end detection
    assign col_inc   = (EW+1)'(r_col) + (EW+1)'(1);
    assign row_inc   = (EW+1)'(r_row) + (EW+1)'(1);
    assign row_end   = col_inc >= (EW+1)'(w_eff);
    assign frame_end = row_end && (row_inc >= (EW+1)'(h_eff));

    // origin, shifted by half the size when centered
    always_comb begin
        if (i_center) begin
            org_x = i_place_x - COORD_W'(w_eff >> 1);
            org_y = i_place_y - COORD_W'(h_eff >> 1);
        end else begin
            org_x = i_place_x;
            org_y = i_place_y;
        end
    end

    assign o_pos.x    = org_x + COORD_W'(r_col);
    assign o_pos.y    = org_y + COORD_W'(r_row);
    assign o_pos.last = frame_end;

    // counters advance on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_adv) begin
            if (row_end) begin
                r_col <= '0;
                if (frame_end) begin
                    r_row <= '0;
                end else begin
                    r_row <= CW'(row_inc);
                end
            end else begin
                r_col <= CW'(col_inc);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/bce_color.sv @@
// pixel color expansion: grey blend, rgb888 truncation or red
`default_nettype none

module bce_color
    import bce_pkg::*;
(
    input  wire logic [7:0]         i_channels,
    input  wire logic [COLOR_W-1:0] i_fore,
    input  wire logic [COLOR_W-1:0] i_back,
    input  wire logic [7:0]         i_byte_first,
    input  wire logic [7:0]         i_byte_second,
    input  wire logic [7:0]         i_byte_third,
    output logic [COLOR_W-1:0]      o_color
);

    // exact x / 255 for x below 16320
    function automatic logic [5:0] div255(input logic [13:0] x);
        logic [14:0] t;
        t = 15'(x) + 15'(x[13:8]) + 15'd1;
        return t[13:8];
    endfunction

    // bg + floor((fg - bg) * grey / 255) on one channel
    function automatic logic [5:0] blend(input logic [5:0] fg, input logic [5:0] bg,
                                         input logic [7:0] grey);
        logic signed [6:0] d;
        logic [5:0]        m;
        logic [13:0]       p;
        logic [5:0]        q;
        d = $signed({1'b0, fg}) - $signed({1'b0, bg});
        m = d[6] ? 6'(-d) : d[5:0];
        p = 14'(m) * 14'(grey);
        if (d[6]) begin
            q = div255(p + 14'd254);
            return bg - q;
        end else begin
            q = div255(p);
            return bg + q;
        end
    endfunction

    logic [5:0] r_bl;
    logic [5:0] g_bl;
    logic [5:0] b_bl;

    // per channel blend in grey mode
    assign r_bl = blend({1'b0, i_fore[15:11]}, {1'b0, i_back[15:11]}, i_byte_first);
    assign g_bl = blend(i_fore[10:5], i_back[10:5], i_byte_first);
    assign b_bl = blend({1'b0, i_fore[4:0]}, {1'b0, i_back[4:0]}, i_byte_first);

    // mode select
    always_comb begin
        if (i_channels == CH_GREY) begin
            o_color = {r_bl[4:0], g_bl, b_bl[4:0]};
        end else if (i_channels == CH_RGB) begin
            o_color = {i_byte_first[7:3], i_byte_second[7:2], i_byte_third[7:3]};
        end else begin
            o_color = COLOR_RED;
        end
    end

endmodule

`default_nettype wire

@@ rtl/bitmap_color_expand_blit.sv @@
// color expansion blit top level: config registers and two stage pipeline
// an accepted request is registered in the input stage, then in the result stage that drives the outputs
// throughput: one pixel per cycle while the output is not stalled, set by the input and result register pair
// stall from the output propagates back only when both stages hold data
// synchronous active low reset clears config to defaults, counters and valids
`default_nettype none

module bitmap_color_expand_blit
    import bce_pkg::*;
#(
    parameter int unsigned MAX_DIM = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [7:0]            i_byte_first,
    input  wire logic [7:0]            i_byte_second,
    input  wire logic [7:0]            i_byte_third,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [COORD_W-1:0]         o_panel_x,
    output logic [COORD_W-1:0]         o_panel_y,
    output logic [COLOR_W-1:0]         o_pixel_color,
    output logic                       o_frame_last
);

    logic [DIM_W-1:0]   r_image_width;
    logic [DIM_W-1:0]   r_image_height;
    logic [COLOR_W-1:0] r_fore_color;
    logic [COLOR_W-1:0] r_back_color;
    logic [COORD_W-1:0] r_place_x;
    logic [COORD_W-1:0] r_place_y;
    logic [7:0]         r_channel_count;
    logic               r_center_mode;

    logic               r_s1_valid;
    t_pos               r_s1_pos;
    logic [7:0]         r_s1_b0;
    logic [7:0]         r_s1_b1;
    logic [7:0]         r_s1_b2;
    logic               r_s2_valid;
    t_pos               r_s2_pos;
    logic [COLOR_W-1:0] r_s2_color;

    logic               in_acc;
    logic               s2_free;
    logic               s1_free;
    logic               s1_move;
    t_pos               n_pos;
    logic [COLOR_W-1:0] n_color;
    t_cfg_idx           cfg_idx;

    // configuration writes
    assign cfg_idx = t_cfg_idx'(i_cfg_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width   <= DIM_W'(1);
            r_image_height  <= DIM_W'(1);
            r_fore_color    <= '1;
            r_back_color    <= '0;
            r_place_x       <= '0;
            r_place_y       <= '0;
            r_channel_count <= CH_GREY;
            r_center_mode   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (cfg_idx)
                CFG_IMAGE_WIDTH:   r_image_width   <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT:  r_image_height  <= i_cfg_data[DIM_W-1:0];
                CFG_FORE_COLOR:    r_fore_color    <= i_cfg_data;
                CFG_BACK_COLOR:    r_back_color    <= i_cfg_data;
                CFG_PLACE_X:       r_place_x       <= i_cfg_data;
                CFG_PLACE_Y:       r_place_y       <= i_cfg_data;
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[7:0];
                CFG_CENTER_MODE:   r_center_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipeline flow control
    assign s2_free = !r_s2_valid || !i_stall;
    assign s1_move = r_s1_valid && s2_free;
    assign s1_free = !r_s1_valid || s2_free;
    assign o_stall = !s1_free;
    assign in_acc  = i_valid && s1_free;

    // position of the accepted request
    bce_pos #(
        .MAX_DIM (MAX_DIM)
    ) u_pos (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (in_acc),
        .i_width   (r_image_width),
        .i_height  (r_image_height),
        .i_place_x (r_place_x),
        .i_place_y (r_place_y),
        .i_center  (r_center_mode),
        .o_pos     (n_pos)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pos <= n_pos;
            r_s1_b0  <= i_byte_first;
            r_s1_b1  <= i_byte_second;
            r_s1_b2  <= i_byte_third;
        end
    end

    // color expansion between the stages
    bce_color u_color (
        .i_channels    (r_channel_count),
        .i_fore        (r_fore_color),
        .i_back        (r_back_color),
        .i_byte_first  (r_s1_b0),
        .i_byte_second (r_s1_b1),
        .i_byte_third  (r_s1_b2),
        .o_color       (n_color)
    );

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_pos   <= r_s1_pos;
            r_s2_color <= n_color;
        end
    end

    assign o_valid       = r_s2_valid;
    assign o_panel_x     = r_s2_pos.x;
    assign o_panel_y     = r_s2_pos.y;
    assign o_pixel_color = r_s2_color;
    assign o_frame_last  = r_s2_pos.last;

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// self-checking testbench for the color expansion blit: pixel requests in, pixel writes out
import bce_pkg::*;

// largest image side the block is built for
localparam int unsigned PANEL_MAX_DIM = 256;

// one expected pixel write on the panel side
typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] color;
    logic               last;
} pixel_write_t;

// full register set loaded between phases
typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [COLOR_W-1:0] fore;
    logic [COLOR_W-1:0] back;
    logic [COORD_W-1:0] place_x;
    logic [COORD_W-1:0] place_y;
    logic [7:0]         chans;
    logic               centered;
} blit_cfg_t;

// shadow of the blit: registers, raster position and pixel writes still to come
class pixel_scoreboard;
    logic [DIM_W-1:0]   width_q;
    logic [DIM_W-1:0]   height_q;
    logic [COLOR_W-1:0] fore_q;
    logic [COLOR_W-1:0] back_q;
    logic [COORD_W-1:0] place_x_q;
    logic [COORD_W-1:0] place_y_q;
    logic [7:0]         chans_q;
    logic               centered_q;
    int unsigned        col;
    int unsigned        row;
    pixel_write_t       pending[$];
    int unsigned        mismatches;

    function new();
        width_q    = DIM_W'(1);
        height_q   = DIM_W'(1);
        fore_q     = 16'hFFFF;
        back_q     = 16'h0000;
        place_x_q  = 16'h0000;
        place_y_q  = 16'h0000;
        chans_q    = CH_GREY;
        centered_q = 1'b0;
        col        = 0;
        row        = 0;
        mismatches = 0;
    endfunction

    function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_IMAGE_WIDTH:   width_q    = data[DIM_W-1:0];
            CFG_IMAGE_HEIGHT:  height_q   = data[DIM_W-1:0];
            CFG_FORE_COLOR:    fore_q     = data[COLOR_W-1:0];
            CFG_BACK_COLOR:    back_q     = data[COLOR_W-1:0];
            CFG_PLACE_X:       place_x_q  = data[COORD_W-1:0];
            CFG_PLACE_Y:       place_y_q  = data[COORD_W-1:0];
            CFG_CHANNEL_COUNT: chans_q    = data[7:0];
            CFG_CENTER_MODE:   centered_q = data[0];
            default: ;
        endcase
    endfunction

    // zero acts as one, oversize saturates
    static function int unsigned eff_dim(logic [DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > PANEL_MAX_DIM) return PANEL_MAX_DIM;
        return 32'(v);
    endfunction

    // bg + floor((fg - bg) * grey / 255), rounding toward minus infinity
    static function int blend_channel(int fg, int bg, int grey);
        int prod;
        prod = (fg - bg) * grey;
        if (prod >= 0) return bg + prod / 255;
        return bg - (-prod + 254) / 255;
    endfunction

    function void note_pixel(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
        int unsigned        w;
        int unsigned        h;
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
        logic [4:0]         red;
        logic [5:0]         green;
        logic [4:0]         blue;
        pixel_write_t       next_write;
        w  = eff_dim(width_q);
        h  = eff_dim(height_q);
        ox = place_x_q;
        oy = place_y_q;
        // centering pulls the origin back by half the effective size
        if (centered_q) begin
            ox = place_x_q - COORD_W'(w >> 1);
            oy = place_y_q - COORD_W'(h >> 1);
        end
        // color expansion per channel mode
        if (chans_q == CH_GREY) begin
            red   = 5'(blend_channel(int'(fore_q[15:11]), int'(back_q[15:11]), int'(b0)));
            green = 6'(blend_channel(int'(fore_q[10:5]), int'(back_q[10:5]), int'(b0)));
            blue  = 5'(blend_channel(int'(fore_q[4:0]), int'(back_q[4:0]), int'(b0)));
            next_write.color = {red, green, blue};
        end else if (chans_q == CH_RGB) begin
            next_write.color = {b0[7:3], b1[7:2], b2[7:3]};
        end else begin
            next_write.color = COLOR_RED;
        end
        next_write.x    = ox + COORD_W'(col);
        next_write.y    = oy + COORD_W'(row);
        next_write.last = 1'b0;
        // raster advance, tolerant of a size that shrank mid-frame
        if (col + 1 >= w) begin
            col = 0;
            if (row + 1 >= h) begin
                row = 0;
                next_write.last = 1'b1;
            end else begin
                row++;
            end
        end else begin
            col++;
        end
        pending.push_back(next_write);
    endfunction

    function void check_write(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic [COLOR_W-1:0] color, logic last);
        pixel_write_t want;
        if (pending.size() == 0) begin
            $error("pixel write with no request pending: x %h y %h color %h", x, y, color);
            mismatches++;
            return;
        end
        want = pending.pop_front();
        if (x !== want.x) begin
            $error("panel_x: expected %h, got %h", want.x, x);
            mismatches++;
        end
        if (y !== want.y) begin
            $error("panel_y: expected %h, got %h", want.y, y);
            mismatches++;
        end
        if (color !== want.color) begin
            $error("pixel_color: expected %h, got %h", want.color, color);
            mismatches++;
        end
        if (last !== want.last) begin
            $error("frame_last: expected %b, got %b", want.last, last);
            mismatches++;
        end
    endfunction
endclass

module testbench;
    import bce_pkg::*;

    localparam int ITEM_TARGET  = 1600;
    localparam int TAIL_ITEMS   = 150;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES  = 48;
    localparam int IDLE_LIMIT   = 2000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic [7:0]            i_byte_first;
    logic [7:0]            i_byte_second;
    logic [7:0]            i_byte_third;
    logic                  o_valid;
    logic                  i_stall;
    logic [COORD_W-1:0]    o_panel_x;
    logic [COORD_W-1:0]    o_panel_y;
    logic [COLOR_W-1:0]    o_pixel_color;
    logic                  o_frame_last;

    pixel_scoreboard board = new();
    int   gap_pct      = 20;
    int   stall_pct    = 20;
    logic hold_request = 1'b0;
    int   idle_cycles  = 0;

    bitmap_color_expand_blit #(
        .MAX_DIM(PANEL_MAX_DIM)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_byte_first  (i_byte_first),
        .i_byte_second (i_byte_second),
        .i_byte_third  (i_byte_third),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_panel_x     (o_panel_x),
        .o_panel_y     (o_panel_y),
        .o_pixel_color (o_pixel_color),
        .o_frame_last  (o_frame_last)
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // mostly small sides, now and then zero or oversize
    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return DIM_W'($urandom_range(1, 8));
        if (r < 85) return DIM_W'($urandom_range(9, 40));
        if (r < 92) return '0;
        return DIM_W'($urandom_range(256, 511));
    endfunction

    function automatic logic [15:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int pick_pct();
        int r;
        r = $urandom_range(0, 2);
        if (r == 0) return 0;
        if (r == 1) return 10;
        return 30;
    endfunction

    // let the pipeline empty, then load every register
    task automatic load_config(input blit_cfg_t c);
        t_cfg_idx idx;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        idx = idx.first();
        repeat (idx.num()) begin
            @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx;
            case (idx)
                CFG_IMAGE_WIDTH:   i_cfg_data <= CFG_DATA_W'(c.width);
                CFG_IMAGE_HEIGHT:  i_cfg_data <= CFG_DATA_W'(c.height);
                CFG_FORE_COLOR:    i_cfg_data <= c.fore;
                CFG_BACK_COLOR:    i_cfg_data <= c.back;
                CFG_PLACE_X:       i_cfg_data <= c.place_x;
                CFG_PLACE_Y:       i_cfg_data <= c.place_y;
                CFG_CHANNEL_COUNT: i_cfg_data <= CFG_DATA_W'(c.chans);
                CFG_CENTER_MODE:   i_cfg_data <= CFG_DATA_W'(c.centered);
                default:           i_cfg_data <= '0;
            endcase
            @(posedge i_clk);
            idx = idx.next();
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // offer one pixel request, maybe after a gap, and wait until it is taken
    task automatic offer_pixel(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
        int gap;
        @(negedge i_clk);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 10);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_byte_first  <= b0;
        i_byte_second <= b1;
        i_byte_third  <= b2;
        do @(posedge i_clk); while (o_stall);
    endtask

    // receiver back-pressure: random bursts plus one long hold on request
    initial begin : receiver
        int burst;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_stall <= 1'b0;
            end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                burst = $urandom_range(1, 10);
                i_stall <= 1'b1;
                repeat (burst) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // sample both handshakes and config writes at the rising edge
    always @(posedge i_clk) begin
        logic busy;
        busy = 1'b0;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                board.note_pixel(i_byte_first, i_byte_second, i_byte_third);
                busy = 1'b1;
            end
            if (i_cfg_we) begin
                board.write_reg(i_cfg_index, i_cfg_data);
                busy = 1'b1;
            end
            if (o_valid && !i_stall) begin
                board.check_write(o_panel_x, o_panel_y, o_pixel_color, o_frame_last);
                busy = 1'b1;
            end
        end
        idle_cycles = busy ? 0 : idle_cycles + 1;
    end

    // watchdog on cycles with no handshake at all
    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        blit_cfg_t cfg;
        int        sent;
        int        phase;
        int        burst;
        int        r;
        logic      tail;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_IMAGE_WIDTH;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_byte_first  = 8'h00;
        i_byte_second = 8'h00;
        i_byte_third  = 8'h00;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: single pixel frames, white on black
        offer_pixel(8'h00, 8'h00, 8'h00);
        offer_pixel(8'hFF, 8'hFF, 8'hFF);

        // grey blend with falling channels, origin at the wrap edge
        load_config(blit_cfg_t'{width: 9'd3, height: 9'd2, fore: 16'h0000, back: 16'hFFFF,
                                place_x: 16'hFFFF, place_y: 16'hFFFE, chans: CH_GREY,
                                centered: 1'b0});
        offer_pixel(8'h00, 8'hFF, 8'hFF);
        offer_pixel(8'hFF, 8'h00, 8'h00);
        offer_pixel(8'h80, 8'h5A, 8'hA5);
        offer_pixel(8'h01, 8'h00, 8'h00);
        offer_pixel(8'hFE, 8'hFF, 8'hFF);
        offer_pixel(8'h7F, 8'h3C, 8'hC3);

        // rgb888 truncation, centered on column and row zero
        load_config(blit_cfg_t'{width: 9'd2, height: 9'd2, fore: 16'hF81F, back: 16'h07E0,
                                place_x: 16'h0000, place_y: 16'h0000, chans: CH_RGB,
                                centered: 1'b1});
        offer_pixel(8'hFF, 8'hFF, 8'hFF);
        offer_pixel(8'h00, 8'h00, 8'h00);
        offer_pixel(8'hAA, 8'h55, 8'hF0);
        offer_pixel(8'h55, 8'hAA, 8'h0F);

        // unsupported count, zero sizes acting as one
        load_config(blit_cfg_t'{width: 9'd0, height: 9'd0, fore: 16'hFFFF, back: 16'h0000,
                                place_x: 16'h8000, place_y: 16'h7FFF, chans: 8'd0,
                                centered: 1'b1});
        offer_pixel(8'h12, 8'h34, 8'h56);
        offer_pixel(8'hED, 8'hCB, 8'hA9);

        // oversize sizes saturate, frame left open on purpose
        load_config(blit_cfg_t'{width: 9'h1FF, height: 9'h100, fore: 16'h1234, back: 16'hFEDC,
                                place_x: 16'h0040, place_y: 16'hFFFF, chans: 8'hFF,
                                centered: 1'b1});
        offer_pixel(8'h00, 8'h00, 8'h00);
        offer_pixel(8'hFF, 8'hFF, 8'hFF);
        offer_pixel(8'h5A, 8'h5A, 8'h5A);

        // width shrinks below the running column: row and frame end at once
        load_config(blit_cfg_t'{width: 9'd2, height: 9'd1, fore: 16'h1234, back: 16'hFEDC,
                                place_x: 16'h0010, place_y: 16'h0020, chans: CH_GREY,
                                centered: 1'b0});
        offer_pixel(8'hC0, 8'h00, 8'h00);
        offer_pixel(8'h40, 8'h00, 8'h00);
        offer_pixel(8'hFF, 8'h00, 8'h00);
        sent = 20;

        // random phases, quiet tail at the end
        phase = 0;
        while (sent < ITEM_TARGET) begin
            tail         = (sent >= ITEM_TARGET - TAIL_ITEMS);
            cfg.width    = pick_dim();
            cfg.height   = pick_dim();
            cfg.fore     = pick_word();
            cfg.back     = pick_word();
            cfg.place_x  = pick_word();
            cfg.place_y  = pick_word();
            r = $urandom_range(0, 99);
            if (r < 45) cfg.chans = CH_GREY;
            else if (r < 80) cfg.chans = CH_RGB;
            else cfg.chans = 8'($urandom_range(0, 255));
            cfg.centered = 1'($urandom_range(0, 1));
            load_config(cfg);
            gap_pct   = tail ? 0 : pick_pct();
            stall_pct = tail ? 0 : pick_pct();
            // long receiver hold while requests keep coming
            if (phase == 4) begin
                gap_pct      = 0;
                hold_request = 1'b1;
            end
            burst = $urandom_range(10, 120);
            repeat (burst) begin
                offer_pixel(pick_byte(), pick_byte(), pick_byte());
                sent++;
            end
            phase++;
        end

        // drain and settle
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/bce_pkg.sv
rtl/bce_pos.sv
rtl/bce_color.sv
rtl/bitmap_color_expand_blit.sv
dv/testbench.sv
